// File: design/ffa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and constants of the first-fit block allocator.
// Has no dependencies; ffa_ctrl, ffa_datapath and the top level use it.
package ffa_pkg;

  localparam int MAX_BLOCKS_DEF       = 64;
  localparam int HEADER_BYTES_DEF     = 24;
  localparam int HEAP_OFFSET_BITS_DEF = 20;

  localparam int ADDR_W  = 48;
  localparam int BYTES_W = 21;
  localparam int SIZE_W  = 22;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;

  localparam logic [BYTES_W-1:0] HEAP_MIN    = 21'd64;
  localparam logic [BYTES_W-1:0] HEAP_MAX    = 21'd1048576;
  localparam logic [SIZE_W-1:0]  ALIGN_MASK  = 22'd7;
  localparam int                 SPLIT_SLACK = 32;

  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEAP_SIZE = 1'b1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_NO_MEMORY = 3'd2,
    ST_FREED     = 3'd3,
    ST_NULL      = 3'd4,
    ST_UNKNOWN   = 3'd5,
    ST_DOUBLE    = 3'd6
  } status_t;

  typedef struct packed {
    logic               kind;
    logic [BYTES_W-1:0] request_bytes;
    logic [ADDR_W-1:0]  release_address;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  granted_address;
    logic [2:0]         status;
    logic [BYTES_W-1:0] used_bytes;
    logic [BYTES_W-1:0] free_bytes;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic init;
    logic chk;
    logic scan;
    logic wnew;
    logic whit;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic init_pend;
    logic quick;
    logic match;
    logic last;
    logic found;
    logic split;
    logic wr;
  } sts_t;

endpackage
`default_nettype wire

// File: design/ffa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-port RAM with a registered read.
// Has no dependencies.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: design/ffa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Controller state machine of the allocator: sequences table set-up, the scan,
// the write-back and the result. Depends on ffa_pkg.
module ffa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire ffa_pkg::sts_t sts,
  output logic               busy,
  output ffa_pkg::cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_INIT = 8'b00000010,
    S_CHK  = 8'b00000100,
    S_SCAN = 8'b00001000,
    S_DEC  = 8'b00010000,
    S_WNEW = 8'b00100000,
    S_WHIT = 8'b01000000,
    S_FIN  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (sts.init_pend) begin
          state_nxt = S_INIT;
        end else if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = sts.quick ? S_FIN : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.match || sts.last) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.found && sts.split) begin
          state_nxt = S_WNEW;
        end else if (sts.found && sts.wr) begin
          state_nxt = S_WHIT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_WNEW: begin
        cmd.wnew  = 1'b1;
        state_nxt = S_WHIT;
      end
      S_WHIT: begin
        cmd.whit  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE) || sts.init_pend;

endmodule
`default_nettype wire

// File: design/ffa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the allocator: configuration registers, the linked block table
// in RAM, the hit registers and the result word. Depends on ffa_pkg, ffa_ram.
module ffa_datapath #(
  parameter int MAX_BLOCKS       = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES     = ffa_pkg::HEADER_BYTES_DEF,
  parameter int HEAP_OFFSET_BITS = ffa_pkg::HEAP_OFFSET_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ffa_pkg::cmd_t                 cmd,
  output ffa_pkg::sts_t                      sts,
  input  wire ffa_pkg::in_word_t             in_word,
  input  wire logic                          base_we,
  input  wire logic                          size_we,
  input  wire logic [ffa_pkg::PDATA_W-1:0]   cfg_data,
  output logic      [ffa_pkg::ADDR_W-1:0]    heap_base,
  output logic      [ffa_pkg::BYTES_W-1:0]   heap_len,
  output logic                               out_valid,
  output ffa_pkg::out_word_t                 out_word
);

  localparam int IDXW  = $clog2(MAX_BLOCKS);
  localparam int CNTW  = $clog2(MAX_BLOCKS + 1);
  localparam int OFFW  = HEAP_OFFSET_BITS;
  localparam int BW    = ffa_pkg::BYTES_W;
  localparam int SZW   = ffa_pkg::SIZE_W;
  localparam int AW    = ffa_pkg::ADDR_W;
  localparam int SW    = ((OFFW > SZW) ? OFFW : SZW) + 1;
  localparam int ENT_W = IDXW + OFFW + BW + 1;

  logic [AW-1:0]   base_r;
  logic [BW-1:0]   hsize_r;
  logic            init_pend_r;
  logic [CNTW-1:0] count_r;
  logic [BW-1:0]   used_r, used_nxt;
  logic            kind_r;
  logic [SZW-1:0]  size_r;
  logic [AW-1:0]   rel_r;
  logic            quick_r;
  logic [IDXW-1:0] k_r, rd_idx_r;
  logic            found_r, split_r;
  logic [IDXW-1:0] hit_idx_r, hit_next_r;
  logic [OFFW-1:0] hit_off_r;
  logic [BW-1:0]   hit_len_r;
  logic            hit_taken_r;
  logic            out_valid_r;
  ffa_pkg::out_word_t out_word_r;

  logic             ram_we;
  logic [IDXW-1:0]  ram_addr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;
  logic [IDXW-1:0]  rd_next;
  logic [OFFW-1:0]  rd_off;
  logic             rd_taken;
  logic [BW-1:0]    rd_len;
  logic [BW-1:0]    wsize;
  logic [BW-1:0]    cfg_size;
  logic             match;
  logic             last;
  logic             split_ok;
  logic [OFFW-1:0]  new_off;
  logic [BW-1:0]    new_len;
  logic [BW-1:0]    fin_len;
  logic [2:0]       status;
  logic [SZW-1:0]   size_in;

  assign rd_next  = ram_rdata[ENT_W-1 -: IDXW];
  assign rd_off   = ram_rdata[BW+1 +: OFFW];
  assign rd_len   = ram_rdata[1 +: BW];
  assign rd_taken = ram_rdata[0];
  assign wsize    = size_r[BW-1:0];

  assign match = (kind_r == ffa_pkg::KIND_ALLOC) ?
                 (!rd_taken && (SZW'(rd_len) >= size_r)) :
                 ((base_r + AW'(rd_off) + AW'(HEADER_BYTES)) == rel_r);
  assign last  = (CNTW'(k_r) + CNTW'(1)) == count_r;
  assign split_ok = (kind_r == ffa_pkg::KIND_ALLOC) &&
                    ((SZW + 1)'(rd_len) >= ((SZW + 1)'(size_r) + (SZW + 1)'(HEADER_BYTES) +
                                            (SZW + 1)'(ffa_pkg::SPLIT_SLACK))) &&
                    (count_r < CNTW'(MAX_BLOCKS));

  assign new_off = OFFW'(SW'(hit_off_r) + SW'(HEADER_BYTES) + SW'(size_r));
  assign new_len = BW'(hit_len_r - wsize - BW'(HEADER_BYTES));
  assign fin_len = split_r ? wsize : hit_len_r;

  always_comb begin
    cfg_size = cfg_data[BW-1:0];
    if (cfg_size < ffa_pkg::HEAP_MIN) begin
      cfg_size = ffa_pkg::HEAP_MIN;
    end else if (cfg_size > ffa_pkg::HEAP_MAX) begin
      cfg_size = ffa_pkg::HEAP_MAX;
    end
  end

  always_comb begin
    ram_we    = cmd.init | cmd.wnew | cmd.whit;
    ram_addr  = '0;
    ram_wdata = {IDXW'(0), OFFW'(0), BW'(hsize_r - BW'(HEADER_BYTES)), 1'b0};
    if (cmd.scan) begin
      ram_addr = rd_next;
    end else if (cmd.wnew) begin
      ram_addr  = count_r[IDXW-1:0];
      ram_wdata = {hit_next_r, new_off, new_len, 1'b0};
    end else if (cmd.whit) begin
      ram_addr  = hit_idx_r;
      ram_wdata = {split_r ? count_r[IDXW-1:0] : hit_next_r, hit_off_r, fin_len,
                   kind_r == ffa_pkg::KIND_ALLOC};
    end
  end

  ffa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    used_nxt = used_r;
    if (kind_r == ffa_pkg::KIND_ALLOC) begin
      if (quick_r) begin
        status = ffa_pkg::ST_ZERO_SIZE;
      end else if (!found_r) begin
        status = ffa_pkg::ST_NO_MEMORY;
      end else begin
        status   = ffa_pkg::ST_ALLOCATED;
        used_nxt = BW'(used_r + fin_len + BW'(HEADER_BYTES));
      end
    end else begin
      if (quick_r) begin
        status = ffa_pkg::ST_NULL;
      end else if (!found_r) begin
        status = ffa_pkg::ST_UNKNOWN;
      end else if (!hit_taken_r) begin
        status = ffa_pkg::ST_DOUBLE;
      end else begin
        status   = ffa_pkg::ST_FREED;
        used_nxt = BW'(used_r - hit_len_r - BW'(HEADER_BYTES));
      end
    end
  end

  assign size_in = (SZW'(in_word.request_bytes) + ffa_pkg::ALIGN_MASK) & ~ffa_pkg::ALIGN_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      hsize_r     <= ffa_pkg::HEAP_MAX;
      init_pend_r <= 1'b1;
      count_r     <= CNTW'(1);
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
      if (base_we) begin
        base_r <= cfg_data[AW-1:0];
      end
      if (size_we) begin
        hsize_r     <= cfg_size;
        init_pend_r <= 1'b1;
        count_r     <= CNTW'(1);
        used_r      <= '0;
      end else if (cmd.init) begin
        init_pend_r <= 1'b0;
      end else if (cmd.fin) begin
        used_r <= used_nxt;
        if (found_r && split_r && kind_r == ffa_pkg::KIND_ALLOC) begin
          count_r <= count_r + CNTW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_word.kind;
      size_r  <= size_in;
      rel_r   <= in_word.release_address;
      quick_r <= (in_word.kind == ffa_pkg::KIND_ALLOC) ? (in_word.request_bytes == '0) :
                                                         (in_word.release_address == '0);
      found_r <= 1'b0;
      split_r <= 1'b0;
    end
    if (cmd.chk) begin
      k_r      <= '0;
      rd_idx_r <= '0;
    end
    if (cmd.scan) begin
      if (match || last) begin
        found_r     <= match;
        split_r     <= split_ok;
        hit_idx_r   <= rd_idx_r;
        hit_next_r  <= rd_next;
        hit_off_r   <= rd_off;
        hit_len_r   <= rd_len;
        hit_taken_r <= rd_taken;
      end else begin
        k_r      <= k_r + IDXW'(1);
        rd_idx_r <= rd_next;
      end
    end
    if (cmd.fin) begin
      out_word_r.granted_address <= (status == ffa_pkg::ST_ALLOCATED) ?
                                    (base_r + AW'(hit_off_r) + AW'(HEADER_BYTES)) : '0;
      out_word_r.status     <= status;
      out_word_r.used_bytes <= used_nxt;
      out_word_r.free_bytes <= BW'(hsize_r - used_nxt);
    end
  end

  assign sts.init_pend = init_pend_r;
  assign sts.quick     = quick_r;
  assign sts.match     = match;
  assign sts.last      = last;
  assign sts.found     = found_r;
  assign sts.split     = split_r;
  assign sts.wr        = (kind_r == ffa_pkg::KIND_ALLOC) || hit_taken_r;

  assign heap_base = base_r;
  assign heap_len  = hsize_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

// File: design/first_fit_block_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the first-fit block allocator: register port, controller and datapath.
// Depends on ffa_pkg, ffa_ctrl, ffa_datapath.

// One request is taken while start is high and busy is low, and its result word appears
// on out_word for a single cycle with out_valid high; the receiver cannot stall it. A
// request walks the block table in address order, one entry per cycle through the table
// RAM's registered read port, until it finds a matching entry or reaches the last one.
// Zero-size and null requests skip the walk and go straight to the result. After reset
// and after each write of the heap size the block is busy while the first table entry
// is written.
module first_fit_block_allocator_top #(
  parameter int MAX_BLOCKS       = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES     = ffa_pkg::HEADER_BYTES_DEF,
  parameter int HEAP_OFFSET_BITS = ffa_pkg::HEAP_OFFSET_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire ffa_pkg::in_word_t           in_word,
  output logic                             out_valid,
  output ffa_pkg::out_word_t               out_word,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ffa_pkg::PADDR_W-1:0] paddr,
  input  wire logic [ffa_pkg::PDATA_W-1:0] pwdata,
  output logic      [ffa_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);

  ffa_pkg::cmd_t cmd;
  ffa_pkg::sts_t sts;
  logic          wr_en;
  logic [ffa_pkg::ADDR_W-1:0]  heap_base;
  logic [ffa_pkg::BYTES_W-1:0] heap_len;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == ffa_pkg::REG_HEAP_BASE) ?
                  ffa_pkg::PDATA_W'(heap_base) : ffa_pkg::PDATA_W'(heap_len);

  ffa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  ffa_datapath #(
    .MAX_BLOCKS       (MAX_BLOCKS),
    .HEADER_BYTES     (HEADER_BYTES),
    .HEAP_OFFSET_BITS (HEAP_OFFSET_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .base_we   (wr_en && paddr[3] == ffa_pkg::REG_HEAP_BASE),
    .size_we   (wr_en && paddr[3] == ffa_pkg::REG_HEAP_SIZE),
    .cfg_data  (pwdata),
    .heap_base (heap_base),
    .heap_len  (heap_len),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_result_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid)
    else $error("finished request gave no result");

  a_ok_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != ffa_pkg::ST_ALLOCATED |-> out_word.granted_address == '0)
    else $error("address given on a failed or free request");

endmodule
`default_nettype wire
